### rtl/ikts_pkg.sv
// ============================================================================
// ikts_pkg
// Shared widths, constants, types and helpers of the arm kinematics unit.
// ============================================================================
package ikts_pkg;

    localparam int CORDIC_STAGES_DEF = 18;
    localparam int ATAN_TAB_LEN      = 24;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int CFG_W     = 8;

    localparam int X_W  = 14;
    localparam int Z_W  = 13;
    localparam int SH_W = 15;
    localparam int FO_W = 15;
    localparam int LI_W = 16;

    localparam int NUM_W  = 30;
    localparam int DEN_W  = 25;
    localparam int BDEN_W = 36;
    localparam int RAD_W  = 50;
    localparam int ROOT_W = 25;
    localparam int REM_W  = 27;

    localparam int NLANE      = 3;
    localparam int NORM_W     = 42;
    localparam int NORM_TOP   = 41;
    localparam int NORM_STEPS = 6;
    localparam int CORD_W     = 45;
    localparam int ANG_W      = 20;

    localparam int K_W = 29;
    localparam logic signed [K_W-1:0] K_SHOULDER = 29'sd120157959;
    localparam logic signed [K_W-1:0] K_FOREARM  = 29'sd194393048;
    localparam logic signed [K_W-1:0] K_LIFT     = 29'sd109806622;

    localparam int         DIV62_SHIFT = 28;
    localparam logic [22:0] DIV62_MUL  = 23'd4329605;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 20'sd102944;

    localparam logic signed [19:0] SH_MIN = -20'sd11520;
    localparam logic signed [19:0] SH_MAX = 20'sd5760;
    localparam logic signed [19:0] FO_MIN = -20'sd10000;
    localparam logic signed [19:0] FO_MAX = 20'sd14300;
    localparam logic signed [19:0] LI_MIN = -20'sd26810;
    localparam logic signed [19:0] LI_MAX = 20'sd26810;

    localparam logic [7:0] UPPER_ARM_RESET = 8'd212;
    localparam logic [7:0] FORE_ARM_RESET  = 8'd200;

    typedef enum logic {
        REG_UPPER_ARM = 1'b0,
        REG_FORE_ARM  = 1'b1
    } cfg_reg_t;

    typedef logic signed [NORM_W-1:0] nword_t;
    typedef nword_t nlanes_t [NLANE];
    typedef logic signed [CORD_W-1:0] cword_t;
    typedef cword_t clanes_t [NLANE];
    typedef logic signed [ANG_W-1:0] ang_t;
    typedef ang_t alanes_t [NLANE];

    function automatic logic [NORM_W-1:0] nmag(input nword_t v);
        return v[NORM_W-1] ? NORM_W'(-v) : NORM_W'(v);
    endfunction

    function automatic int norm_shift(input int k);
        return 32 >> k;
    endfunction

    function automatic ang_t atan_q(input int i);
        ang_t r;
        unique case (i)
            0:       r = 20'sd51472;
            1:       r = 20'sd30386;
            2:       r = 20'sd16055;
            3:       r = 20'sd8150;
            4:       r = 20'sd4091;
            5:       r = 20'sd2047;
            6:       r = 20'sd1024;
            7:       r = 20'sd512;
            8:       r = 20'sd256;
            9:       r = 20'sd128;
            10:      r = 20'sd64;
            11:      r = 20'sd32;
            12:      r = 20'sd16;
            13:      r = 20'sd8;
            14:      r = 20'sd4;
            15:      r = 20'sd2;
            16:      r = 20'sd1;
            default: r = 20'sd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/ikts_sqrt_cell.sv
// ============================================================================
// ikts_sqrt_cell
// One digit of the integer square root; passes side data to the next cell.
// ============================================================================
module ikts_sqrt_cell #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        valid_i,
    input  logic [ikts_pkg::RAD_W-1:0]  rad_i,
    input  logic [ikts_pkg::REM_W-1:0]  rem_i,
    input  logic [ikts_pkg::ROOT_W-1:0] root_i,
    input  logic [SIDE_W-1:0]           side_i,
    output logic                        valid_o,
    output logic [ikts_pkg::RAD_W-1:0]  rad_o,
    output logic [ikts_pkg::REM_W-1:0]  rem_o,
    output logic [ikts_pkg::ROOT_W-1:0] root_o,
    output logic [SIDE_W-1:0]           side_o
);
    import ikts_pkg::*;

    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;
    logic              valid_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        cur       = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
        trial     = {root_i, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? (cur - trial) : cur;
        root_next = {root_i[ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= {rad_i[RAD_W-3:0], 2'b00};
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= side_i;
    end

    assign valid_o = valid_reg;
    assign rad_o   = rad_reg;
    assign rem_o   = rem_reg;
    assign root_o  = root_reg;
    assign side_o  = side_reg;

endmodule

### rtl/ikts_norm_cell.sv
// ============================================================================
// ikts_norm_cell
// One step of operand normalization: shifts a vector pair up when it is small.
// ============================================================================
module ikts_norm_cell #(
    parameter int SHIFT  = 1,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              valid_i,
    input  ikts_pkg::nlanes_t x_i,
    input  ikts_pkg::nlanes_t y_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output ikts_pkg::nlanes_t x_o,
    output ikts_pkg::nlanes_t y_o,
    output logic [SIDE_W-1:0] side_o
);
    import ikts_pkg::*;

    localparam logic [NORM_W-1:0] LIMIT = NORM_W'(1) << (NORM_TOP - SHIFT);

    logic [NORM_W-1:0] mx [NLANE];
    logic [NORM_W-1:0] my [NLANE];
    nlanes_t           x_next;
    nlanes_t           y_next;
    logic              valid_reg;
    nlanes_t           x_reg;
    nlanes_t           y_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            mx[l] = nmag(x_i[l]);
            my[l] = nmag(y_i[l]);
            if ((mx[l] < LIMIT) && (my[l] < LIMIT)) begin
                x_next[l] = x_i[l] <<< SHIFT;
                y_next[l] = y_i[l] <<< SHIFT;
            end else begin
                x_next[l] = x_i[l];
                y_next[l] = y_i[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        side_reg <= side_i;
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign side_o  = side_reg;

endmodule

### rtl/ikts_cordic_cell.sv
// ============================================================================
// ikts_cordic_cell
// One vectoring rotation of three CORDIC lanes, with angle accumulation.
// ============================================================================
module ikts_cordic_cell #(
    parameter int STAGE  = 0,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              valid_i,
    input  ikts_pkg::clanes_t x_i,
    input  ikts_pkg::clanes_t y_i,
    input  ikts_pkg::alanes_t z_i,
    input  logic [SIDE_W-1:0] side_i,
    output logic              valid_o,
    output ikts_pkg::clanes_t x_o,
    output ikts_pkg::clanes_t y_o,
    output ikts_pkg::alanes_t z_o,
    output logic [SIDE_W-1:0] side_o
);
    import ikts_pkg::*;

    localparam ang_t ATAN_C = atan_q(STAGE);

    clanes_t           xs;
    clanes_t           ys;
    clanes_t           x_next;
    clanes_t           y_next;
    alanes_t           z_next;
    logic              valid_reg;
    clanes_t           x_reg;
    clanes_t           y_reg;
    alanes_t           z_reg;
    logic [SIDE_W-1:0] side_reg;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            xs[l] = x_i[l] >>> STAGE;
            ys[l] = y_i[l] >>> STAGE;
            if (y_i[l] == '0) begin
                x_next[l] = x_i[l];
                y_next[l] = y_i[l];
                z_next[l] = z_i[l];
            end else if (!y_i[l][CORD_W-1]) begin
                x_next[l] = x_i[l] + ys[l];
                y_next[l] = y_i[l] - xs[l];
                z_next[l] = z_i[l] + ATAN_C;
            end else begin
                x_next[l] = x_i[l] - ys[l];
                y_next[l] = y_i[l] + xs[l];
                z_next[l] = z_i[l] - ATAN_C;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= side_i;
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;
    assign side_o  = side_reg;

endmodule

### rtl/ikts_out_fifo.sv
// ============================================================================
// ikts_out_fifo
// Result queue with a registered output word that decouples the pipeline.
// ============================================================================
module ikts_out_fifo #(
    parameter int AW = 6,
    parameter int W  = 47
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int DEPTH = 1 << AW;

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   fill_reg;
    logic [AW:0]   fill_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [W-1:0]  out_data_reg;
    logic          load;

    always_comb begin
        load        = (fill_reg != '0) && (!out_valid_reg || rd_ready);
        wr_ptr_next = wr_ptr_reg + AW'(wr_en);
        rd_ptr_next = rd_ptr_reg + AW'(load);
        fill_next   = fill_reg + (AW+1)'(wr_en) - (AW+1)'(load);
        if (load) begin
            out_valid_next = 1'b1;
        end else if (rd_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;

endmodule

### rtl/two_link_arm_ik_to_steps_unit.sv
// ============================================================================
// two_link_arm_ik_to_steps_unit
// Two-link planar inverse kinematics from a target point to stepper counts.
// ============================================================================
// Throughput is one word per cycle while s_tready is high (the credit count
// can hold the input); the 25-cell root chain, the normalizer and the CORDIC
// chain are fully pipelined, and a result queue sized to the latency holds
// finished words while the output stalls.
// Reset clears the pipeline valids, the queue and the credit count, and sets
// the link lengths to 212 mm and 200 mm.
module two_link_arm_ik_to_steps_unit #(
    parameter int CORDIC_STAGES = ikts_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  ikts_pkg::cfg_reg_t             cfg_index,
    input  logic [ikts_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // target_x, target_y, target_z
    input  logic [ikts_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // shoulder_steps, forearm_steps, lift_steps
    output logic [ikts_pkg::M_TDATA_W-1:0] m_tdata,
    // out_of_reach
    output logic [0:0]                     m_tuser
);
    import ikts_pkg::*;

    localparam int LAT     = 44 + CORDIC_STAGES;
    localparam int FIFO_AW = $clog2(LAT + 3);
    localparam int DEPTH   = 1 << FIFO_AW;
    localparam int WORD_W  = SH_W + FO_W + LI_W + 1;
    localparam int T_W     = 27;
    localparam int Q_W     = 24;

    typedef struct packed {
        logic signed [X_W-1:0]    x;
        logic signed [X_W-1:0]    y;
        logic signed [Z_W-1:0]    z;
        logic signed [NUM_W-1:0]  num;
        logic signed [BDEN_W-1:0] bden;
        logic                     oor;
    } root_side_t;

    typedef struct packed {
        logic signed [Z_W-1:0] z;
        logic                  oor;
    } ang_side_t;

    localparam int RS_W = $bits(root_side_t);
    localparam int AS_W = $bits(ang_side_t);

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v,
                                                 input logic signed [19:0] lo,
                                                 input logic signed [19:0] hi);
        logic signed [19:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return r[15:0];
    endfunction

    logic [7:0] upper_reg;
    logic [7:0] fore_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= UPPER_ARM_RESET;
            fore_reg  <= FORE_ARM_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_UPPER_ARM: upper_reg <= cfg_wr_data;
                REG_FORE_ARM:  fore_reg  <= cfg_wr_data;
            endcase
        end
    end

    // Credit count covers every word in the pipeline, the queue and the output.
    logic           s_acc;
    logic           m_acc;
    logic [FIFO_AW:0] cnt_reg;
    logic [FIFO_AW:0] cnt_next;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = cnt_reg < (FIFO_AW+1)'(DEPTH);
    assign cnt_next = cnt_reg + (FIFO_AW+1)'(s_acc) - (FIFO_AW+1)'(m_acc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Front end: squares, law of cosines and operand products.
    logic                       v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [X_W-1:0]      x0_reg, x1_reg, x2_reg, x3_reg, x4_reg;
    logic signed [X_W-1:0]      y0_reg, y1_reg, y2_reg, y3_reg, y4_reg;
    logic signed [Z_W-1:0]      z0_reg, z1_reg, z2_reg, z3_reg, z4_reg;
    logic signed [2*X_W-1:0]    xx1_reg, yy1_reg;
    logic [15:0]                l11_reg, l22_reg, l12_reg;
    logic [16:0]                lsum;
    logic signed [NUM_W-1:0]    num2_reg, num2_next, num3_reg, num4_reg;
    logic [DEN_W-1:0]           den2_reg;
    logic [NUM_W-1:0]           absn;
    logic                       oor3_reg, oor4_reg;
    logic [RAD_W-1:0]           dd3_reg, nn3_reg, rad4_reg;
    logic [DEN_W+7:0]           ld3_reg;
    logic signed [NUM_W+8:0]    ln3_reg;
    logic signed [BDEN_W-1:0]   bden4_reg;

    always_comb begin
        lsum      = {1'b0, l11_reg} + {1'b0, l22_reg};
        num2_next = NUM_W'(xx1_reg) + NUM_W'(yy1_reg) - NUM_W'({lsum, 8'd0});
        absn      = num2_reg[NUM_W-1] ? NUM_W'(-num2_reg) : NUM_W'(num2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= s_acc;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg    <= s_tdata[X_W-1:0];
        y0_reg    <= s_tdata[2*X_W-1:X_W];
        z0_reg    <= s_tdata[2*X_W+Z_W-1:2*X_W];
        xx1_reg   <= x0_reg * x0_reg;
        yy1_reg   <= y0_reg * y0_reg;
        l11_reg   <= upper_reg * upper_reg;
        l22_reg   <= fore_reg * fore_reg;
        l12_reg   <= upper_reg * fore_reg;
        x1_reg    <= x0_reg;
        y1_reg    <= y0_reg;
        z1_reg    <= z0_reg;
        num2_reg  <= num2_next;
        den2_reg  <= {l12_reg, 9'd0};
        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        z2_reg    <= z1_reg;
        oor3_reg  <= (den2_reg == '0) || (absn > NUM_W'(den2_reg));
        dd3_reg   <= den2_reg * den2_reg;
        nn3_reg   <= absn[DEN_W-1:0] * absn[DEN_W-1:0];
        ld3_reg   <= upper_reg * den2_reg;
        ln3_reg   <= num2_reg * $signed({1'b0, fore_reg});
        num3_reg  <= num2_reg;
        x3_reg    <= x2_reg;
        y3_reg    <= y2_reg;
        z3_reg    <= z2_reg;
        rad4_reg  <= dd3_reg - nn3_reg;
        bden4_reg <= BDEN_W'($signed({1'b0, ld3_reg}) + ln3_reg);
        oor4_reg  <= oor3_reg;
        num4_reg  <= num3_reg;
        x4_reg    <= x3_reg;
        y4_reg    <= y3_reg;
        z4_reg    <= z3_reg;
    end

    // Square root chain.
    logic              sq_v    [ROOT_W+1];
    logic [RAD_W-1:0]  sq_rad  [ROOT_W+1];
    logic [REM_W-1:0]  sq_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [RS_W-1:0]   sq_side [ROOT_W+1];
    root_side_t        rs_in;
    root_side_t        rs_out;

    always_comb begin
        rs_in.x    = x4_reg;
        rs_in.y    = y4_reg;
        rs_in.z    = z4_reg;
        rs_in.num  = num4_reg;
        rs_in.bden = bden4_reg;
        rs_in.oor  = oor4_reg;
    end

    assign sq_v[0]    = v4_reg;
    assign sq_rad[0]  = rad4_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = rs_in;
    assign rs_out     = sq_side[ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        ikts_sqrt_cell #(
            .SIDE_W(RS_W)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .valid_i(sq_v[k]),
            .rad_i  (sq_rad[k]),
            .rem_i  (sq_rem[k]),
            .root_i (sq_root[k]),
            .side_i (sq_side[k]),
            .valid_o(sq_v[k+1]),
            .rad_o  (sq_rad[k+1]),
            .rem_o  (sq_rem[k+1]),
            .root_o (sq_root[k+1]),
            .side_o (sq_side[k+1])
        );
    end

    // Operand set-up for the three angle lanes.
    logic                     v5_reg;
    logic [ROOT_W-1:0]        s5_reg;
    logic [ROOT_W+7:0]        ls5_reg;
    root_side_t               rs5_reg;
    ang_side_t                as5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else begin
            v5_reg <= sq_v[ROOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        s5_reg  <= sq_root[ROOT_W];
        ls5_reg <= fore_reg * sq_root[ROOT_W];
        rs5_reg <= rs_out;
    end

    logic            nm_v    [NORM_STEPS+1];
    nlanes_t         nm_x    [NORM_STEPS+1];
    nlanes_t         nm_y    [NORM_STEPS+1];
    logic [AS_W-1:0] nm_side [NORM_STEPS+1];

    always_comb begin
        as5.z      = rs5_reg.z;
        as5.oor    = rs5_reg.oor;
        nm_y[0][0] = nword_t'(s5_reg);
        nm_x[0][0] = nword_t'(rs5_reg.num);
        nm_y[0][1] = nword_t'(ls5_reg);
        nm_x[0][1] = nword_t'(rs5_reg.bden);
        nm_y[0][2] = nword_t'(rs5_reg.y);
        nm_x[0][2] = nword_t'(rs5_reg.x);
    end

    assign nm_v[0]    = v5_reg;
    assign nm_side[0] = as5;

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        ikts_norm_cell #(
            .SHIFT (norm_shift(k)),
            .SIDE_W(AS_W)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .valid_i(nm_v[k]),
            .x_i    (nm_x[k]),
            .y_i    (nm_y[k]),
            .side_i (nm_side[k]),
            .valid_o(nm_v[k+1]),
            .x_o    (nm_x[k+1]),
            .y_o    (nm_y[k+1]),
            .side_o (nm_side[k+1])
        );
    end

    // Quadrant fold for negative x.
    logic            cd_v    [CORDIC_STAGES+1];
    clanes_t         cd_x    [CORDIC_STAGES+1];
    clanes_t         cd_y    [CORDIC_STAGES+1];
    alanes_t         cd_z    [CORDIC_STAGES+1];
    logic [AS_W-1:0] cd_side [CORDIC_STAGES+1];
    logic            vq_reg;
    clanes_t         xq_reg, xq_next, yq_reg, yq_next;
    alanes_t         zq_reg, zq_next;
    logic [AS_W-1:0] sq_reg;
    clanes_t         xe, ye;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            xe[l] = CORD_W'(nm_x[NORM_STEPS][l]);
            ye[l] = CORD_W'(nm_y[NORM_STEPS][l]);
            if (xe[l][CORD_W-1]) begin
                if (!ye[l][CORD_W-1]) begin
                    xq_next[l] = ye[l];
                    yq_next[l] = -xe[l];
                    zq_next[l] = HALF_PI_Q;
                end else begin
                    xq_next[l] = -ye[l];
                    yq_next[l] = xe[l];
                    zq_next[l] = -HALF_PI_Q;
                end
            end else begin
                xq_next[l] = xe[l];
                yq_next[l] = ye[l];
                zq_next[l] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vq_reg <= 1'b0;
        end else begin
            vq_reg <= nm_v[NORM_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        xq_reg <= xq_next;
        yq_reg <= yq_next;
        zq_reg <= zq_next;
        sq_reg <= nm_side[NORM_STEPS];
    end

    assign cd_v[0]    = vq_reg;
    assign cd_x[0]    = xq_reg;
    assign cd_y[0]    = yq_reg;
    assign cd_z[0]    = zq_reg;
    assign cd_side[0] = sq_reg;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        ikts_cordic_cell #(
            .STAGE (k),
            .SIDE_W(AS_W)
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .valid_i(cd_v[k]),
            .x_i    (cd_x[k]),
            .y_i    (cd_y[k]),
            .z_i    (cd_z[k]),
            .side_i (cd_side[k]),
            .valid_o(cd_v[k+1]),
            .x_o    (cd_x[k+1]),
            .y_o    (cd_y[k+1]),
            .z_o    (cd_z[k+1]),
            .side_o (cd_side[k+1])
        );
    end

    // Back end: angle combination, step scaling, truncation and saturation.
    ang_side_t                 asc;
    logic                      b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg, b5_v_reg;
    logic                      oor1_reg, oor2_reg, oor3b_reg, oor4b_reg, oor5_reg;
    logic signed [ANG_W:0]     th1_reg;
    logic signed [ANG_W-1:0]   th2_reg;
    logic signed [Z_W-1:0]     zb1_reg;
    logic signed [ANG_W+K_W:0] pa_reg;
    logic signed [T_W-1:0]     t_reg;
    logic signed [Z_W+K_W-1:0] pl_reg;
    logic signed [T_W+K_W-1:0] pf_reg;
    logic signed [ANG_W+K_W:0] pa_adj;
    logic signed [Z_W+K_W-1:0] pl_adj;
    logic [T_W+K_W-1:0]        pf_abs;
    logic signed [15:0]        a3_reg, a4_reg, a5_reg;
    logic signed [15:0]        c3_reg, c4_reg, c5_reg;
    logic                      sgn4_reg, sgn5_reg;
    logic [Q_W-1:0]            q4_reg;
    logic [Q_W+22:0]           qm5_reg;
    logic [Q_W+22-DIV62_SHIFT:0] fq;
    logic signed [19:0]        fs;
    logic signed [15:0]        f_sat;
    logic [WORD_W-1:0]         word;
    logic [WORD_W-1:0]         rd_word;

    assign asc = cd_side[CORDIC_STAGES];

    always_comb begin
        pa_adj = pa_reg + (pa_reg[ANG_W+K_W] ? (ANG_W+K_W+1)'(33'h0_FFFF_FFFF)
                                             : (ANG_W+K_W+1)'(0));
        pl_adj = pl_reg + (pl_reg[Z_W+K_W-1] ? (Z_W+K_W)'(25'h0FF_FFFF)
                                             : (Z_W+K_W)'(0));
        pf_abs = pf_reg[T_W+K_W-1] ? (T_W+K_W)'(-pf_reg) : (T_W+K_W)'(pf_reg);
        fq     = qm5_reg[Q_W+22:DIV62_SHIFT];
        fs     = sgn5_reg ? -$signed(20'(fq)) : $signed(20'(fq));
        f_sat  = sat16(fs, FO_MIN, FO_MAX);
        if (oor5_reg) begin
            word = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            word = {1'b0, c5_reg[LI_W-1:0], f_sat[FO_W-1:0], a5_reg[SH_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
            b3_v_reg <= 1'b0;
            b4_v_reg <= 1'b0;
            b5_v_reg <= 1'b0;
        end else begin
            b1_v_reg <= cd_v[CORDIC_STAGES];
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            b5_v_reg <= b4_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        th1_reg   <= (ANG_W+1)'(cd_z[CORDIC_STAGES][2]) -
                     (ANG_W+1)'(cd_z[CORDIC_STAGES][1]);
        th2_reg   <= cd_z[CORDIC_STAGES][0];
        zb1_reg   <= asc.z;
        oor1_reg  <= asc.oor;
        pa_reg    <= th1_reg * K_SHOULDER;
        t_reg     <= T_W'(th1_reg) * 27'sd33 + T_W'(th2_reg) * 27'sd62;
        pl_reg    <= zb1_reg * K_LIFT;
        oor2_reg  <= oor1_reg;
        a3_reg    <= sat16(20'($signed(pa_adj[ANG_W+K_W:32])), SH_MIN, SH_MAX);
        c3_reg    <= sat16(20'($signed(pl_adj[Z_W+K_W-1:24])), LI_MIN, LI_MAX);
        pf_reg    <= t_reg * K_FOREARM;
        oor3b_reg <= oor2_reg;
        sgn4_reg  <= pf_reg[T_W+K_W-1];
        q4_reg    <= pf_abs[T_W+K_W-1:32];
        a4_reg    <= a3_reg;
        c4_reg    <= c3_reg;
        oor4b_reg <= oor3b_reg;
        qm5_reg   <= q4_reg * DIV62_MUL;
        sgn5_reg  <= sgn4_reg;
        a5_reg    <= a4_reg;
        c5_reg    <= c4_reg;
        oor5_reg  <= oor4b_reg;
    end

    ikts_out_fifo #(
        .AW(FIFO_AW),
        .W (WORD_W)
    ) u_out_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (b5_v_reg),
        .wr_data (word),
        .rd_valid(m_tvalid),
        .rd_ready(m_tready),
        .rd_data (rd_word)
    );

    assign m_tdata = M_TDATA_W'(rd_word[WORD_W-2:0]);
    assign m_tuser = rd_word[WORD_W-1];

endmodule

### rtl/ikts_checker.sv
// ============================================================================
// ikts_checker
// Port-level checks of the arm kinematics unit, bound to the top level.
// ============================================================================
module ikts_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ikts_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import ikts_pkg::*;

    // An unreachable target carries all-zero counts.
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("out of reach word with nonzero counts");

    // Shoulder and forearm counts stay inside their saturation ranges.
    a_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[SH_W-1:0]) >= 15'sd0 - 15'sd11520)
                  && ($signed(m_tdata[SH_W-1:0]) <= 15'sd5760)
                  && ($signed(m_tdata[SH_W+FO_W-1:SH_W]) >= 15'sd0 - 15'sd10000)
                  && ($signed(m_tdata[SH_W+FO_W-1:SH_W]) <= 15'sd14300))
        else $error("step count outside its range");

    // A stalled word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind two_link_arm_ik_to_steps_unit ikts_checker u_ikts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
